// ----- rtl/core/bpa_pkg.sv -----
// shared constants, types and codes of the bitmap page allocator
package bpa_pkg;

  localparam int unsigned MAX_PAGES     = 4096;
  localparam int unsigned MAP_WORD_BITS = 64;
  localparam int unsigned MAP_WORDS     = MAX_PAGES / MAP_WORD_BITS;
  localparam int unsigned PAGE_W        = $clog2(MAX_PAGES);
  localparam int unsigned CNT_W         = PAGE_W + 1;
  localparam int unsigned WORD_AW       = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W         = $clog2(MAP_WORD_BITS);

  typedef logic [MAP_WORD_BITS-1:0] map_word_t;
  typedef logic [WORD_AW-1:0]       word_addr_t;
  typedef logic [BIT_W-1:0]         bit_idx_t;
  typedef logic [PAGE_W-1:0]        page_t;
  typedef logic [CNT_W-1:0]         count_t;

  typedef enum logic [1:0] {
    CMD_RESERVE_ALL = 2'd0,
    CMD_MARK_USABLE = 2'd1,
    CMD_ALLOCATE    = 2'd2,
    CMD_FREE        = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NONE_FREE = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  // request bundle from the control fsm to the map memory
  typedef struct packed {
    logic       clear_all;
    logic       rd_en;
    word_addr_t rd_addr;
    logic       wr_en;
    word_addr_t wr_addr;
    map_word_t  wr_data;
  } map_req_t;

endpackage

// ----- rtl/core/bpa_intf.sv -----
// valid/ready channel interfaces of the bitmap page allocator
interface bpa_cmd_if;
  logic          valid;
  logic          ready;
  bpa_pkg::cmd_e command;
  bpa_pkg::page_t page_num;
  modport source (output valid, output command, output page_num, input ready);
  modport sink (input valid, input command, input page_num, output ready);
endinterface

interface bpa_rsp_if;
  logic             valid;
  logic             ready;
  bpa_pkg::status_e status;
  bpa_pkg::page_t   granted_page;
  modport source (output valid, output status, output granted_page, input ready);
  modport sink (input valid, input status, input granted_page, output ready);
endinterface

interface bpa_cfg_if;
  logic            valid;
  logic            ready;
  bpa_pkg::count_t page_count;
  modport source (output valid, output page_count, input ready);
  modport sink (input valid, input page_count, output ready);
endinterface

// ----- rtl/core/bpa_map_mem.sv -----
// used-page map memory with per-word valid bits; invalid words read as all used
module bpa_map_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpa_pkg::map_req_t   req_i,
  output bpa_pkg::map_word_t  rd_data_o
);

  bpa_pkg::map_word_t             map_q [bpa_pkg::MAP_WORDS];
  bpa_pkg::map_word_t             rd_data_q;
  logic [bpa_pkg::MAP_WORDS-1:0]  vld_q;
  logic                           rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= map_q[req_i.rd_addr];
    end
    if (req_i.wr_en) begin
      map_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // reserve-all just drops every valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clear_all) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '1;

endmodule

// ----- rtl/core/bpa_scan.sv -----
// masked lowest-free-bit search over one map word
module bpa_scan (
  input  bpa_pkg::map_word_t word_i,
  input  logic               first_i,
  input  bpa_pkg::bit_idx_t  lo_bit_i,
  input  logic               last_i,
  input  bpa_pkg::bit_idx_t  hi_bit_i,
  output logic               found_o,
  output bpa_pkg::bit_idx_t  bit_o
);

  bpa_pkg::map_word_t lo_mask;
  bpa_pkg::map_word_t hi_mask;
  bpa_pkg::map_word_t free_bits;

  // first word starts at the hint, last word stops at the page count
  assign lo_mask   = first_i ? ({bpa_pkg::MAP_WORD_BITS{1'b1}} << lo_bit_i) : '1;
  assign hi_mask   = (last_i && (hi_bit_i != '0)) ?
                     ~({bpa_pkg::MAP_WORD_BITS{1'b1}} << hi_bit_i) : '1;
  assign free_bits = ~word_i & lo_mask & hi_mask;
  assign found_o   = |free_bits;

  always_comb begin
    bit_o = '0;
    for (int i = bpa_pkg::MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        bit_o = bpa_pkg::bit_idx_t'(i);
      end
    end
  end

endmodule

// ----- rtl/core/bitmap_page_allocator_unit.sv -----
// top level of the bitmap page allocator: control fsm, map memory and word scan
//
// keeps one used bit per page (1 = used) in a 64 x 64-bit map memory plus a
// next-fit search hint. every command beat gives exactly one response beat.
// reserve-all marks every page used and zeroes the hint (it drops the
// per-word valid bits, so no sweep is needed; after reset the map reads as all
// used the same way). mark-usable and free read the word, write it back, then
// respond; with the index out of range they respond without touching the map.
// allocate reads the word holding the hint, then one map word after another up
// to the word of the last live page, stopping at the first free page; with the
// hint at or past the page count it answers without a scan. the read port delivers
// one word a cycle and the scan finds the lowest free page in it. a response may
// wait in the output register while the next command beat is taken. page_count
// is clamped to 4096 and must only be written while the block is idle; the
// config channel is always ready.
module bitmap_page_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpa_cmd_if.sink     cmd_i,
  bpa_rsp_if.source   rsp_o,
  bpa_cfg_if.sink     cfg_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RMW  = 4'b0010,
    S_SCAN = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  bpa_pkg::count_t    page_count_q;
  bpa_pkg::page_t     hint_q, hint_d;
  bpa_pkg::cmd_e      cmd_q, cmd_d;
  bpa_pkg::page_t     idx_q, idx_d;
  bpa_pkg::word_addr_t scan_word_q, scan_word_d;
  logic               first_q, first_d;

  // pending response, then the output register
  bpa_pkg::status_e   res_status_q, res_status_d;
  bpa_pkg::page_t     res_grant_q, res_grant_d;
  logic               out_valid_q;
  bpa_pkg::status_e   out_status_q;
  bpa_pkg::page_t     out_grant_q;
  logic               out_free;

  bpa_pkg::map_req_t  map_req;
  bpa_pkg::map_word_t rd_data;

  bpa_pkg::count_t    limit;
  bpa_pkg::count_t    limit_m1;
  bpa_pkg::word_addr_t last_word;
  logic               scan_last;
  logic               scan_found;
  bpa_pkg::bit_idx_t  scan_bit;
  logic               cmd_beat;

  // effective page count, clamped to the map size
  assign limit     = (page_count_q > bpa_pkg::count_t'(bpa_pkg::MAX_PAGES)) ?
                     bpa_pkg::count_t'(bpa_pkg::MAX_PAGES) : page_count_q;
  assign limit_m1  = limit - 1'b1;
  assign last_word = limit_m1[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
  assign scan_last = (scan_word_q == last_word);

  assign cmd_i.ready = (state_q == S_IDLE);
  assign cmd_beat    = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;

  assign out_free     = !out_valid_q || rsp_o.ready;
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.granted_page = out_grant_q;

  bpa_map_mem u_map_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (map_req),
    .rd_data_o (rd_data)
  );

  bpa_scan u_scan (
    .word_i   (rd_data),
    .first_i  (first_q),
    .lo_bit_i (hint_q[bpa_pkg::BIT_W-1:0]),
    .last_i   (scan_last),
    .hi_bit_i (limit[bpa_pkg::BIT_W-1:0]),
    .found_o  (scan_found),
    .bit_o    (scan_bit)
  );

  always_comb begin
    state_d      = state_q;
    hint_d       = hint_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    scan_word_d  = scan_word_q;
    first_d      = first_q;
    res_status_d = res_status_q;
    res_grant_d  = res_grant_q;
    map_req      = '0;

    case (state_q)
      S_IDLE: begin
        if (cmd_beat) begin
          cmd_d        = cmd_i.command;
          idx_d        = cmd_i.page_num;
          res_grant_d  = '0;
          res_status_d = bpa_pkg::ST_DONE;
          case (cmd_i.command)
            bpa_pkg::CMD_RESERVE_ALL: begin
              map_req.clear_all = 1'b1;
              hint_d            = '0;
              state_d           = S_RESP;
            end
            bpa_pkg::CMD_ALLOCATE: begin
              // a hint past the limit scans nothing
              if ({1'b0, hint_q} >= limit) begin
                res_status_d = bpa_pkg::ST_NONE_FREE;
                state_d      = S_RESP;
              end else begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = hint_q[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
                scan_word_d     = hint_q[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
                first_d         = 1'b1;
                state_d         = S_SCAN;
              end
            end
            default: begin
              // mark-usable and free share the read-modify-write path
              if ({1'b0, cmd_i.page_num} >= limit) begin
                res_status_d = bpa_pkg::ST_RANGE;
                state_d      = S_RESP;
              end else begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = cmd_i.page_num[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
                state_d         = S_RMW;
              end
            end
          endcase
        end
      end
      S_RMW: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = idx_q[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
        map_req.wr_data = rd_data &
                          ~(bpa_pkg::map_word_t'(1) << idx_q[bpa_pkg::BIT_W-1:0]);
        if (cmd_q == bpa_pkg::CMD_FREE) begin
          hint_d = idx_q;
        end
        state_d = S_RESP;
      end
      S_SCAN: begin
        first_d = 1'b0;
        if (scan_found) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_addr = scan_word_q;
          map_req.wr_data = rd_data | (bpa_pkg::map_word_t'(1) << scan_bit);
          hint_d          = {scan_word_q, scan_bit};
          res_grant_d     = {scan_word_q, scan_bit};
          state_d         = S_RESP;
        end else if (scan_last) begin
          res_status_d = bpa_pkg::ST_NONE_FREE;
          state_d      = S_RESP;
        end else begin
          // next word's read goes out now, its data lands next cycle
          map_req.rd_en   = 1'b1;
          map_req.rd_addr = scan_word_q + 1'b1;
          scan_word_d     = scan_word_q + 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      hint_q       <= '0;
      page_count_q <= '0;
      out_valid_q  <= 1'b0;
      first_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      hint_q  <= hint_d;
      first_q <= first_d;
      if (cfg_i.valid && cfg_i.ready) begin
        page_count_q <= cfg_i.page_count;
      end
      if ((state_q == S_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    idx_q        <= idx_d;
    scan_word_q  <= scan_word_d;
    res_status_q <= res_status_d;
    res_grant_q  <= res_grant_d;
    if ((state_q == S_RESP) && out_free) begin
      out_status_q <= res_status_q;
      out_grant_q  <= res_grant_q;
    end
  end

  // a scan only runs with the hint inside the live page range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ({1'b0, hint_q} < limit))
    else $error("scan running with hint outside page range");

  // the scan never walks past the word holding the last live page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_word_q <= last_word))
    else $error("scan word beyond last live word");

  // a response leaving the fsm always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RESP) && out_free) |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("response lost on its way to the output register");

  // a nonzero granted page is always a live page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_grant_q != '0)) |->
      ((out_status_q == bpa_pkg::ST_DONE) && ({1'b0, out_grant_q} < limit)))
    else $error("granted page outside page range");

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench of the bitmap page allocator with its own next-fit model
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 5;
  // longest quiet stretch: the long response hold-off plus the longest scan and gaps
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  // drain_all has already seen every response; the tail only lets the clock run on
  localparam int unsigned TAIL_CYCLES    = 20;

  typedef struct packed {
    bpa_pkg::cmd_e  command;
    bpa_pkg::page_t page_num;
  } cmd_beat_t;

  typedef struct packed {
    bpa_pkg::status_e status;
    bpa_pkg::page_t   granted_page;
  } rsp_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bpa_cmd_if cmd_if ();
  bpa_rsp_if rsp_if ();
  bpa_cfg_if cfg_if ();

  bitmap_page_allocator_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // allocator model state: one used bit per page, the next-fit hint, live page count
  logic [bpa_pkg::MAX_PAGES-1:0] used_pages;
  int unsigned                   search_hint;
  int unsigned                   pages_live;

  cmd_beat_t   pending_cmds[$];   // beats waiting for the driver
  rsp_beat_t   awaited_rsps[$];   // predicted responses, oldest first
  int unsigned cmds_queued   = 0;
  int unsigned cmds_accepted = 0;
  int unsigned mismatches    = 0;

  logic        cmd_fired;         // command beat taken at the last rising edge
  int unsigned send_gap    = 0;
  int unsigned rsp_stall   = 0;
  logic        burst_mode  = 1'b0; // no send gaps and no random response stalls
  logic        want_hold   = 1'b0;
  logic        hold_used;
  int unsigned hold_left;
  int unsigned idle_cycles;
  rsp_beat_t   oldest_rsp;

  // mostly short gaps, now and then a long one
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // next-fit allocator: applies one command beat and returns its response
  function automatic rsp_beat_t model_command(cmd_beat_t c);
    rsp_beat_t   r;
    int unsigned p;
    r.status       = bpa_pkg::ST_DONE;
    r.granted_page = '0;
    case (c.command)
      bpa_pkg::CMD_RESERVE_ALL: begin
        used_pages  = '1;
        search_hint = 0;
      end
      bpa_pkg::CMD_MARK_USABLE: begin
        // hint is left where it was
        if (c.page_num >= pages_live) r.status = bpa_pkg::ST_RANGE;
        else used_pages[c.page_num] = 1'b0;
      end
      bpa_pkg::CMD_ALLOCATE: begin
        // scan upward from the hint, no wrap; a hint past the count finds nothing
        r.status = bpa_pkg::ST_NONE_FREE;
        for (p = search_hint; p < pages_live && r.status != bpa_pkg::ST_DONE; p++) begin
          if (!used_pages[p]) begin
            used_pages[p]  = 1'b1;
            search_hint    = p;
            r.status       = bpa_pkg::ST_DONE;
            r.granted_page = bpa_pkg::page_t'(p);
          end
        end
      end
      default: begin
        // free: a page already free is fine, the hint still moves
        if (c.page_num >= pages_live) begin
          r.status = bpa_pkg::ST_RANGE;
        end else begin
          used_pages[c.page_num] = 1'b0;
          search_hint            = c.page_num;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic queue_command(input bpa_pkg::cmd_e op, input bpa_pkg::page_t idx);
    pending_cmds.push_back('{command: op, page_num: idx});
    cmds_queued++;
  endtask

  // every queued beat taken and answered
  task automatic drain_all();
    while (cmds_accepted != cmds_queued || awaited_rsps.size() != 0) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic set_page_count(input bpa_pkg::count_t value);
    @(negedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.page_count <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    // counts above the map size saturate
    pages_live = (value > bpa_pkg::MAX_PAGES) ? bpa_pkg::MAX_PAGES : value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // random traffic at one page count: mostly in-range indices, some edges, some noise
  task automatic random_phase(input bpa_pkg::count_t value, input int unsigned n_items,
                              input bit no_gaps);
    int unsigned    k;
    int unsigned    r;
    bpa_pkg::cmd_e  op;
    bpa_pkg::page_t idx;
    set_page_count(value);
    burst_mode <= no_gaps;
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3)       op = bpa_pkg::CMD_RESERVE_ALL;
      else if (r < 30) op = bpa_pkg::CMD_MARK_USABLE;
      else if (r < 70) op = bpa_pkg::CMD_ALLOCATE;
      else             op = bpa_pkg::CMD_FREE;
      r = $urandom_range(0, 99);
      if (pages_live == 0 || r < 15) begin
        idx = bpa_pkg::page_t'($urandom);
      end else if (r < 25) begin
        case ($urandom_range(0, 2))
          0: idx = '0;
          1: idx = bpa_pkg::page_t'(pages_live - 1);
          default: idx = bpa_pkg::page_t'((pages_live >= bpa_pkg::MAX_PAGES) ?
                                          bpa_pkg::MAX_PAGES - 1 : pages_live);
        endcase
      end else begin
        idx = bpa_pkg::page_t'($urandom_range(0, pages_live - 1));
      end
      queue_command(op, idx);
    end
    drain_all();
  endtask

  // command driver: a new beat goes out at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (cmd_fired || !cmd_if.valid) begin
        if (send_gap != 0) begin
          send_gap--;
          cmd_if.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd_if.valid    <= 1'b1;
          cmd_if.command  <= pending_cmds[0].command;
          cmd_if.page_num <= pending_cmds[0].page_num;
          void'(pending_cmds.pop_front());
          send_gap = burst_mode ? 0 : next_gap();
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // long response hold-off, counted in its own process
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // response ready: random stalls, none in burst mode, low for the whole hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
      end else if (rsp_stall != 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if (!burst_mode && $urandom_range(0, 3) == 0) rsp_stall = next_gap();
      end
    end
  end

  // monitor: check response beats first, then predict for a newly taken command beat
  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_fired <= 1'b0;
    end else begin
      cmd_fired <= cmd_if.valid && cmd_if.ready;
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_rsps.size() == 0) begin
          report_mismatch($sformatf("response beat with none outstanding (status %0d page %0d)",
                                    rsp_if.status, rsp_if.granted_page));
        end else begin
          oldest_rsp = awaited_rsps.pop_front();
          if (rsp_if.status !== oldest_rsp.status)
            report_mismatch($sformatf("status %0d, wanted %0d",
                                      rsp_if.status, oldest_rsp.status));
          if (rsp_if.granted_page !== oldest_rsp.granted_page)
            report_mismatch($sformatf("granted_page %0d, wanted %0d",
                                      rsp_if.granted_page, oldest_rsp.granted_page));
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        awaited_rsps.push_back(model_command('{command: cmd_if.command,
                                               page_num: cmd_if.page_num}));
        cmds_accepted++;
      end
    end
  end

  // watchdog: too long without any beat on any channel
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $realtime, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    // known levels on every input from time zero
    cmd_if.valid      = 1'b0;
    cmd_if.command    = bpa_pkg::CMD_RESERVE_ALL;
    cmd_if.page_num   = '0;
    rsp_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.page_count = '0;
    // model reset state: all used, hint and count zero
    used_pages  = '1;
    search_hint = 0;
    pages_live  = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // page count still zero after reset: hint at the count, every index out of range
    queue_command(bpa_pkg::CMD_ALLOCATE, '0);
    queue_command(bpa_pkg::CMD_FREE, bpa_pkg::page_t'(bpa_pkg::MAX_PAGES - 1));
    drain_all();

    // all-ones count saturates to the full map
    set_page_count('1);
    // index ignored
    queue_command(bpa_pkg::CMD_RESERVE_ALL, bpa_pkg::page_t'(bpa_pkg::MAX_PAGES - 1));
    queue_command(bpa_pkg::CMD_ALLOCATE, '0);               // nothing free
    queue_command(bpa_pkg::CMD_MARK_USABLE, '0);
    queue_command(bpa_pkg::CMD_MARK_USABLE, bpa_pkg::page_t'(bpa_pkg::MAX_PAGES - 1));
    // first page of word 1
    queue_command(bpa_pkg::CMD_MARK_USABLE, bpa_pkg::page_t'(bpa_pkg::MAP_WORD_BITS));
    // index ignored
    queue_command(bpa_pkg::CMD_ALLOCATE, bpa_pkg::page_t'(bpa_pkg::MAX_PAGES - 1));
    queue_command(bpa_pkg::CMD_ALLOCATE, '0);
    queue_command(bpa_pkg::CMD_ALLOCATE, '0);               // top page, full scan
    queue_command(bpa_pkg::CMD_ALLOCATE, '0);               // hint at the top, none left
    queue_command(bpa_pkg::CMD_FREE, bpa_pkg::page_t'(bpa_pkg::MAX_PAGES - 1));
    // freeing a free page
    queue_command(bpa_pkg::CMD_FREE, bpa_pkg::page_t'(bpa_pkg::MAX_PAGES - 1));
    queue_command(bpa_pkg::CMD_ALLOCATE, '0);
    queue_command(bpa_pkg::CMD_MARK_USABLE, bpa_pkg::page_t'(5));   // below the hint
    queue_command(bpa_pkg::CMD_ALLOCATE, '0);               // no wrap, so none found
    queue_command(bpa_pkg::CMD_FREE, bpa_pkg::page_t'(200));
    drain_all();

    // count lowered under the hint, then edges of the small range
    set_page_count(bpa_pkg::count_t'(10));
    queue_command(bpa_pkg::CMD_ALLOCATE, '0);               // hint past the count
    queue_command(bpa_pkg::CMD_MARK_USABLE, bpa_pkg::page_t'(10));  // just out of range
    queue_command(bpa_pkg::CMD_MARK_USABLE, bpa_pkg::page_t'(9));
    queue_command(bpa_pkg::CMD_FREE, bpa_pkg::page_t'(3));
    queue_command(bpa_pkg::CMD_ALLOCATE, '0);
    queue_command(bpa_pkg::CMD_ALLOCATE, '0);
    drain_all();

    random_phase('0, 100, 1'b0);
    random_phase(bpa_pkg::count_t'(1), 150, 1'b0);
    random_phase(bpa_pkg::count_t'(bpa_pkg::MAP_WORD_BITS), 200, 1'b0);
    random_phase(bpa_pkg::count_t'(bpa_pkg::MAP_WORD_BITS + 1), 200, 1'b1);
    random_phase(bpa_pkg::count_t'(bpa_pkg::MAX_PAGES), 250, 1'b0);
    random_phase(bpa_pkg::count_t'(bpa_pkg::MAX_PAGES - 1), 200, 1'b0);
    random_phase(bpa_pkg::count_t'(bpa_pkg::MAX_PAGES + 1), 150, 1'b0);
    random_phase(bpa_pkg::count_t'($urandom_range(1, bpa_pkg::MAX_PAGES)), 200, 1'b0);
    // receiver holds off while the sender keeps offering, so the block backs up
    want_hold <= 1'b1;
    random_phase(bpa_pkg::count_t'(bpa_pkg::MAP_WORD_BITS), 150, 1'b1);
    random_phase(bpa_pkg::count_t'(300), 250, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
